### rtl/spot_pkg.sv
// Shared widths, codes, word types and helpers of the shape pair overlap test.
package spot_pkg;

	localparam int COORD_W    = 21;
	localparam int PACK_W     = 63;
	localparam int RAD_W      = 16;
	localparam int KIND_W     = 2;
	localparam int SAMP_W     = 24;
	localparam int DELTA_W    = 25;
	localparam int MAG_W      = 20;
	localparam int DIST_W     = 40;
	localparam int FULLD_W    = 50;
	localparam int RSUM_W     = 20;
	localparam int NRM_W      = 16;
	localparam int NRM_PACK_W = 48;
	localparam int NSLOT      = 9;
	localparam int SQRT_STEPS = 28;
	localparam int ROOT_W     = 28;
	localparam int SREM_W     = 30;
	localparam int SQX_W      = 56;
	localparam int DIV_STEPS  = 15;
	localparam int DIV_W      = 44;
	localparam int PROD_W     = 36;
	localparam int Y_W        = 40;
	localparam int Z_W        = 26;
	localparam int ZK_W       = 58;

	localparam logic [KIND_W-1:0] KIND_BOX     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CAPSULE = 2'd2;

	localparam logic [NRM_W-1:0]   ONE_Q14   = 16'd16384;
	localparam logic signed [Y_W-1:0] PT_BIAS  = 40'sd49152;
	localparam logic signed [Y_W-1:0] Z_OFFSET = 40'sd25165824;
	localparam logic signed [Z_W:0]   Z_UNBIAS = 27'sd8388608;
	localparam logic [31:0]        RECIP3    = 32'd1431655765;
	localparam logic signed [Z_W:0] PT_MAX   = 27'sd1048575;
	localparam logic signed [Z_W:0] PT_MIN   = -27'sd1048576;

	// Word handed from the front part to the back part through the queue.
	typedef struct packed {
		logic                           hit;
		logic [2:0][DELTA_W-1:0]        d;
		logic [DIST_W-1:0]              dist_sq;
		logic [2:0][SAMP_W-1:0]         b6;
		logic [RAD_W-1:0]               rb;
	} spot_entry_t;

	// Per-word context carried along the back pipeline.
	typedef struct packed {
		logic                           hit;
		logic                           zero;
		logic [2:0]                     sgn;
		logic [2:0][MAG_W-1:0]          mag;
		logic [2:0][SAMP_W-1:0]         b6;
		logic [RAD_W-1:0]               rb;
	} spot_carry_t;

	// Sample point in units of 1/3072 m: 6*base + (tip - base)*w.
	function automatic logic [2:0][SAMP_W-1:0] samp3(
		input logic [PACK_W-1:0] base,
		input logic [PACK_W-1:0] tip,
		input logic [2:0]        w
	);
		logic [2:0][SAMP_W-1:0] res;
		logic signed [SAMP_W+1:0] bs, ds, r;
		for (int c = 0; c < 3; c++) begin
			bs = (SAMP_W+2)'($signed(base[COORD_W*c +: COORD_W]));
			ds = (SAMP_W+2)'($signed(tip[COORD_W*c +: COORD_W])) - bs;
			r  = (bs <<< 2) + (bs <<< 1) + ds * $signed({{(SAMP_W-2){1'b0}}, w});
			res[c] = r[SAMP_W-1:0];
		end
		return res;
	endfunction

endpackage

### rtl/spot_if.sv
// Handshake channels of the shape pair overlap test: pair words in, result words out.
interface spot_pair_if import spot_pkg::*;;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   first_kind;
	logic [PACK_W-1:0]   first_base;
	logic [PACK_W-1:0]   first_tip;
	logic [RAD_W-1:0]    first_radius;
	logic [KIND_W-1:0]   second_kind;
	logic [PACK_W-1:0]   second_base;
	logic [PACK_W-1:0]   second_tip;
	logic [RAD_W-1:0]    second_radius;

	modport source (output valid, first_kind, first_base, first_tip, first_radius,
		second_kind, second_base, second_tip, second_radius, input ready);
	modport sink (input valid, first_kind, first_base, first_tip, first_radius,
		second_kind, second_base, second_tip, second_radius, output ready);
endinterface

interface spot_result_if import spot_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  overlap;
	logic [NRM_PACK_W-1:0] contact_normal;
	logic [PACK_W-1:0]     contact_point;

	modport source (output valid, overlap, contact_normal, contact_point, input ready);
	modport sink (input valid, overlap, contact_normal, contact_point, output ready);
endinterface

### rtl/spot_front.sv
// Front part: classifies the pair, runs up to nine sample sphere tests and picks the first hit.
module spot_front import spot_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	spot_pair_if.sink   pair,
	input  logic        full,
	output logic        push,
	output spot_entry_t push_word
);

	logic                      is_cc, is_cb, cap_first, en;
	logic [PACK_W-1:0]         cap_b, cap_t, box_b;
	logic [RAD_W-1:0]          ra, rb;
	logic [RAD_W:0]            rs;
	logic [PACK_W-1:0]         a_b [NSLOT];
	logic [PACK_W-1:0]         a_t [NSLOT];
	logic [2:0]                a_w [NSLOT];
	logic [PACK_W-1:0]         b_b [NSLOT];
	logic [PACK_W-1:0]         b_t [NSLOT];
	logic [2:0]                b_w [NSLOT];
	logic [NSLOT-1:0]          slot_on;

	logic                      v_s1, v_s2, v_s3;
	logic [2:0][SAMP_W-1:0]    a6_s1 [NSLOT];
	logic [2:0][SAMP_W-1:0]    b6_s1 [NSLOT];
	logic [NSLOT-1:0]          on_s1, on_s2;
	logic [RAD_W-1:0]          rb_s1, rb_s2, rb_s3;
	logic [RSUM_W-1:0]         rsum_s1;
	logic [2:0][DELTA_W-1:0]   d_s2 [NSLOT];
	logic [2:0][DELTA_W-1:0]   d_s3 [NSLOT];
	logic [2:0][2*SAMP_W-1:0]  sq_s2 [NSLOT];
	logic [2:0][SAMP_W-1:0]    b6_s2 [NSLOT];
	logic [2:0][SAMP_W-1:0]    b6_s3 [NSLOT];
	logic [2*RSUM_W-1:0]       rsq_s2;
	logic [FULLD_W-1:0]        dist_s3 [NSLOT];
	logic [NSLOT-1:0]          hit_s3;

	// The pipe moves unless a finished word waits on a full queue.
	assign en         = !v_s3 || !full;
	assign pair.ready = en;
	assign push       = v_s3 && !full;

	// Pair classification and choice of the capsule and box roles.
	assign is_cc     = (pair.first_kind == KIND_CAPSULE) && (pair.second_kind == KIND_CAPSULE);
	assign cap_first = (pair.first_kind == KIND_CAPSULE);
	assign is_cb     = (cap_first && pair.second_kind == KIND_BOX) ||
		(pair.first_kind == KIND_BOX && pair.second_kind == KIND_CAPSULE);
	assign cap_b     = cap_first ? pair.first_base : pair.second_base;
	assign cap_t     = cap_first ? pair.first_tip : pair.second_tip;
	assign box_b     = cap_first ? pair.second_base : pair.first_base;
	assign ra        = is_cb ? (cap_first ? pair.first_radius : pair.second_radius)
		: pair.first_radius;
	assign rb        = is_cb ? (cap_first ? pair.second_radius : pair.first_radius)
		: pair.second_radius;
	assign rs        = {1'b0, ra} + {1'b0, rb};

	// Sample slot set-up: slot order follows the order in which hits are ranked.
	always_comb begin
		for (int s = 0; s < NSLOT; s++) begin
			a_b[s]     = pair.first_base;
			a_t[s]     = pair.first_base;
			a_w[s]     = 3'd0;
			b_b[s]     = pair.second_base;
			b_t[s]     = pair.second_base;
			b_w[s]     = 3'd0;
			slot_on[s] = (s == 0);
		end
		if (is_cc) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					a_b[i*3+j]     = pair.first_base;
					a_t[i*3+j]     = pair.first_tip;
					a_w[i*3+j]     = 3'(3*i);
					b_b[i*3+j]     = pair.second_base;
					b_t[i*3+j]     = pair.second_tip;
					b_w[i*3+j]     = 3'(3*j);
					slot_on[i*3+j] = 1'b1;
				end
			end
		end else if (is_cb) begin
			for (int i = 0; i < 4; i++) begin
				a_b[i]     = cap_b;
				a_t[i]     = cap_t;
				a_w[i]     = 3'(2*i);
				b_b[i]     = box_b;
				b_t[i]     = box_b;
				slot_on[i] = 1'b1;
			end
		end
	end

	// Stage 1: sample points and the scaled radius sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NSLOT; s++) begin
				a6_s1[s] <= samp3(a_b[s], a_t[s], a_w[s]);
				b6_s1[s] <= samp3(b_b[s], b_t[s], b_w[s]);
			end
			on_s1   <= slot_on;
			rb_s1   <= rb;
			rsum_s1 <= RSUM_W'({rs, 2'b00}) + RSUM_W'({rs, 1'b0});
		end
	end

	// Stage 2: differences and their squares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [DELTA_W-1:0] dd;
		logic [SAMP_W-1:0]         m;
		if (en) begin
			for (int s = 0; s < NSLOT; s++) begin
				for (int c = 0; c < 3; c++) begin
					dd = DELTA_W'($signed(a6_s1[s][c])) - DELTA_W'($signed(b6_s1[s][c]));
					m  = dd[DELTA_W-1] ? SAMP_W'(-dd) : SAMP_W'(dd);
					d_s2[s][c]  <= dd;
					sq_s2[s][c] <= (2*SAMP_W)'(m) * (2*SAMP_W)'(m);
				end
				b6_s2[s] <= b6_s1[s];
			end
			on_s2  <= on_s1;
			rb_s2  <= rb_s1;
			rsq_s2 <= (2*RSUM_W)'(rsum_s1) * (2*RSUM_W)'(rsum_s1);
		end
	end

	// Stage 3: squared distance and the hit test of each slot.
	always_ff @(posedge clk) begin
		logic [FULLD_W-1:0] sum;
		if (en) begin
			for (int s = 0; s < NSLOT; s++) begin
				sum = FULLD_W'(sq_s2[s][0]) + FULLD_W'(sq_s2[s][1]) + FULLD_W'(sq_s2[s][2]);
				dist_s3[s] <= sum;
				hit_s3[s]  <= on_s2[s] && (sum < FULLD_W'(rsq_s2));
				d_s3[s]    <= d_s2[s];
				b6_s3[s]   <= b6_s2[s];
			end
			rb_s3 <= rb_s2;
		end
	end

	// First hit in slot order goes to the queue.
	always_comb begin
		push_word      = '0;
		push_word.rb   = rb_s3;
		for (int s = NSLOT - 1; s >= 0; s--) begin
			if (hit_s3[s]) begin
				push_word.hit     = 1'b1;
				push_word.d       = d_s3[s];
				push_word.dist_sq = dist_s3[s][DIST_W-1:0];
				push_word.b6      = b6_s3[s];
			end
		end
	end

endmodule

### rtl/spot_fifo.sv
// Short queue that decouples the front part from the back part.
module spot_fifo import spot_pkg::*; #(
	parameter int Depth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  spot_entry_t push_word,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output spot_entry_t pop_word
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	spot_entry_t   mem_q [Depth];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(Depth));
	assign empty    = (cnt_q == '0);
	assign pop_word = mem_q[rd_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth)) else $error("queue count beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("word pushed into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("word popped from an empty queue");

endmodule

### rtl/spot_back.sv
// Back part: square root, normal division and contact point for each queued word.
module spot_back import spot_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fifo_empty,
	input  spot_entry_t  fifo_word,
	output logic         pop,
	spot_result_if.source result
);

	localparam int SQ = SQRT_STEPS;
	localparam int DV = DIV_STEPS;

	logic en;

	logic                    sq_v_s    [SQ+1];
	spot_carry_t             sq_c_s    [SQ+1];
	logic [SREM_W-1:0]       sq_rem_s  [SQ+1];
	logic [ROOT_W-1:0]       sq_root_s [SQ+1];
	logic [SQX_W-1:0]        sq_x_s    [SQ+1];

	logic                    dv_v_s    [DV+1];
	spot_carry_t             dv_c_s    [DV+1];
	logic [ROOT_W-1:0]       dv_f_s    [DV+1];
	logic [2:0][DIV_W-1:0]   dv_rem_s  [DV+1];
	logic [2:0][DV-1:0]      dv_q_s    [DV+1];

	logic                    v_s1, v_s2, v_s3, v_s4, outv_q;
	spot_carry_t             c_s1, c_s2, c_s3, c_s4;
	logic [2:0][NRM_W-1:0]   n_s1, n_s2, n_s3, n_s4;
	logic [2:0][PROD_W-1:0]  prod_s2;
	logic [2:0][Z_W-1:0]     z_s3, z_s4;
	logic [2:0][ZK_W-1:0]    zk_s4;
	logic                    ovl_q;
	logic [NRM_PACK_W-1:0]   nrm_q;
	logic [PACK_W-1:0]       pt_q;

	// The whole pipe moves when the output register is free or being taken.
	assign en                    = !outv_q || result.ready;
	assign pop                   = en && !fifo_empty;
	assign result.valid          = outv_q;
	assign result.overlap        = ovl_q;
	assign result.contact_normal = nrm_q;
	assign result.contact_point  = pt_q;

	// Load: magnitudes, signs and the radicand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= !fifo_empty;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [DELTA_W-1:0] dd;
		logic [DELTA_W-1:0]        ad;
		if (en) begin
			sq_c_s[0].hit  <= fifo_word.hit;
			sq_c_s[0].zero <= (fifo_word.dist_sq == '0);
			sq_c_s[0].b6   <= fifo_word.b6;
			sq_c_s[0].rb   <= fifo_word.rb;
			for (int c = 0; c < 3; c++) begin
				dd = $signed(fifo_word.d[c]);
				ad = dd[DELTA_W-1] ? DELTA_W'(-dd) : DELTA_W'(dd);
				sq_c_s[0].sgn[c] <= dd[DELTA_W-1];
				sq_c_s[0].mag[c] <= ad[MAG_W-1:0];
			end
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_x_s[0]    <= {fifo_word.dist_sq, 16'd0};
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		logic [SREM_W+1:0] cat, trial;
		logic              take;
		assign cat   = {sq_rem_s[k], sq_x_s[k][SQX_W-1 -: 2]};
		assign trial = (SREM_W+2)'({sq_root_s[k], 2'b01});
		assign take  = (cat >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_c_s[k+1]    <= sq_c_s[k];
				sq_x_s[k+1]    <= {sq_x_s[k][SQX_W-3:0], 2'b00};
				sq_rem_s[k+1]  <= take ? SREM_W'(cat - trial) : SREM_W'(cat);
				sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], take};
			end
		end
	end

	// Divider set-up: rounded numerator for each component.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_c_s[0] <= sq_c_s[SQ];
			dv_f_s[0] <= sq_root_s[SQ];
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c] <= {2'b00, sq_c_s[SQ].mag[c], 22'd0}
					+ DIV_W'(sq_root_s[SQ] >> 1);
				dv_q_s[0][c]   <= '0;
			end
		end
	end

	// Restoring division, three lanes, one quotient bit per stage.
	for (genvar k = 0; k < DV; k++) begin : g_div
		localparam int I = DV - 1 - k;
		logic [DIV_W-1:0] sh;
		assign sh = DIV_W'(dv_f_s[k]) << I;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			logic [DV-1:0] qn;
			if (en) begin
				dv_c_s[k+1] <= dv_c_s[k];
				dv_f_s[k+1] <= dv_f_s[k];
				for (int c = 0; c < 3; c++) begin
					qn = dv_q_s[k][c];
					if (dv_rem_s[k][c] >= sh) begin
						dv_rem_s[k+1][c] <= dv_rem_s[k][c] - sh;
						qn[I]            = 1'b1;
					end else begin
						dv_rem_s[k+1][c] <= dv_rem_s[k][c];
					end
					dv_q_s[k+1][c] <= qn;
				end
			end
		end
	end

	// Control of the point stages and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			outv_q <= 1'b0;
		end else if (en) begin
			v_s1   <= dv_v_s[DV];
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			outv_q <= v_s4;
		end
	end

	// Stage 1: signed normal; coincident samples give the up normal.
	always_ff @(posedge clk) begin
		logic [NRM_W-1:0] q;
		if (en) begin
			c_s1 <= dv_c_s[DV];
			for (int c = 0; c < 3; c++) begin
				q = NRM_W'(dv_q_s[DV][c]);
				if (dv_c_s[DV].zero) begin
					n_s1[c] <= (c == 1) ? ONE_Q14 : '0;
				end else begin
					n_s1[c] <= dv_c_s[DV].sgn[c] ? NRM_W'(-q) : q;
				end
			end
		end
	end

	// Stage 2: normal times six times the second radius.
	always_ff @(posedge clk) begin
		logic [RAD_W+2:0] rb6;
		if (en) begin
			c_s2 <= c_s1;
			n_s2 <= n_s1;
			rb6  = (RAD_W+3)'({c_s1.rb, 2'b00}) + (RAD_W+3)'({c_s1.rb, 1'b0});
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= PROD_W'(PROD_W'($signed(n_s1[c]))
					* PROD_W'($signed({1'b0, rb6})));
			end
		end
	end

	// Stage 3: add the centre, round, floor by 2^15 and bias to non-negative.
	always_ff @(posedge clk) begin
		logic signed [Y_W-1:0] y;
		if (en) begin
			c_s3 <= c_s2;
			n_s3 <= n_s2;
			for (int c = 0; c < 3; c++) begin
				y = (Y_W'($signed(c_s2.b6[c])) <<< 14) + Y_W'($signed(prod_s2[c])) + PT_BIAS;
				y = (y >>> 15) + Z_OFFSET;
				z_s3[c] <= y[Z_W-1:0];
			end
		end
	end

	// Stage 4: reciprocal multiply for the division by three.
	always_ff @(posedge clk) begin
		if (en) begin
			c_s4 <= c_s3;
			n_s4 <= n_s3;
			z_s4 <= z_s3;
			for (int c = 0; c < 3; c++) begin
				zk_s4[c] <= ZK_W'(z_s3[c]) * ZK_W'(RECIP3);
			end
		end
	end

	// Output register: quotient correction, unbias, saturation and gating.
	always_ff @(posedge clk) begin
		logic [Z_W-1:0]       q0;
		logic [Z_W:0]         r;
		logic signed [Z_W:0]  v;
		logic [COORD_W-1:0]   p;
		if (en) begin
			ovl_q <= c_s4.hit;
			for (int c = 0; c < 3; c++) begin
				q0 = zk_s4[c][ZK_W-1 -: Z_W];
				r  = (Z_W+1)'(z_s4[c]) - ((Z_W+1)'(q0) << 1) - (Z_W+1)'(q0);
				if (r >= (Z_W+1)'(3)) begin
					q0 = q0 + 1'b1;
				end
				v = $signed({1'b0, q0}) - Z_UNBIAS;
				if (v > PT_MAX) begin
					p = PT_MAX[COORD_W-1:0];
				end else if (v < PT_MIN) begin
					p = PT_MIN[COORD_W-1:0];
				end else begin
					p = v[COORD_W-1:0];
				end
				pt_q[COORD_W*c +: COORD_W]  <= c_s4.hit ? p : '0;
				nrm_q[NRM_W*c +: NRM_W]     <= c_s4.hit ? n_s4[c] : '0;
			end
		end
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		outv_q && !ovl_q |-> (nrm_q == '0) && (pt_q == '0))
		else $error("miss word carries a normal or point");
	a_hit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		outv_q && ovl_q |-> (nrm_q != '0))
		else $error("overlap word with a zero normal");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sq_v_s[SQ]) && $stable(dv_v_s[DV]))
		else $error("back pipe moved while stalled");

endmodule

### rtl/shape_pair_overlap_test.sv
// Top level of the shape pair overlap test: front part, queue and back part.
//
//  channel  | dir | word
//  pair     | in  | two shapes: kind, base, tip, radius each
//  result   | out | overlap flag, contact normal, contact point
//
// One pair word is taken and one result word leaves per cycle unless stalled.
// A pair passes three front stages, the queue, then the 28-step square root,
// the 15-step normal dividers, the point stages and the output register.
// Reset clears every valid flag and the queue pointers; payload is not reset.
// A stall on result holds the back part; the queue of QueueDepth words then
// fills before the front part stops taking pairs.
module shape_pair_overlap_test import spot_pkg::*; #(
	parameter int QueueDepth = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	spot_pair_if.sink      pair,
	spot_result_if.source  result
);

	logic        push, full, pop, empty;
	spot_entry_t push_word, pop_word;

	spot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.full      (full),
		.push      (push),
		.push_word (push_word)
	);

	spot_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_word  (pop_word)
	);

	spot_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (empty),
		.fifo_word  (pop_word),
		.pop        (pop),
		.result     (result)
	);

endmodule

### bench/shape_pair_overlap_test_tb.sv
// Self-checking testbench of the shape pair overlap test.
`timescale 1ns / 100ps

module shape_pair_overlap_test_tb import spot_pkg::*;;

	localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ODD    = 2'd3;

	typedef struct {
		logic                  overlap;
		logic [NRM_PACK_W-1:0] normal;
		logic [PACK_W-1:0]     point;
	} contact_t;

	typedef struct {
		logic              hit;
		longint            n[3];
		longint            p[3];
	} sample_hit_t;

	logic clk;
	logic arst_n;
	bit   failed;
	bit   idle_on;
	bit   hold_off;
	contact_t expected_contacts[$];

	spot_pair_if   pair ();
	spot_result_if result ();

	shape_pair_overlap_test i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair.sink),
		.result (result.source)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// One signed Q11.9 coordinate out of a packed triple.
	function automatic longint coord_of(logic [PACK_W-1:0] packed_v, int c);
		logic signed [COORD_W-1:0] v;
		v = packed_v[COORD_W*c +: COORD_W];
		return longint'(v);
	endfunction

	// Sample point in units of 1/3072 m at weight w out of six.
	function automatic void sample_point(logic [PACK_W-1:0] base, logic [PACK_W-1:0] tip,
			longint w, output longint pt[3]);
		for (int c = 0; c < 3; c++)
			pt[c] = 6 * coord_of(base, c) + (coord_of(tip, c) - coord_of(base, c)) * w;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint div_floor(longint x, longint d);
		if (x >= 0)
			return x / d;
		return -((-x + d - 1) / d);
	endfunction

	// Overlap test of two sample spheres, with normal and contact point.
	function automatic sample_hit_t sphere_overlap(longint a[3], longint ra, longint b[3],
			longint rb);
		sample_hit_t h;
		longint d[3];
		longint unsigned dist2, rsum, f, m;
		longint q, x, v;
		h.hit = 1'b0;
		dist2 = 0;
		for (int c = 0; c < 3; c++) begin
			h.n[c] = 0;
			h.p[c] = 0;
			d[c] = a[c] - b[c];
			m = d[c] < 0 ? -d[c] : d[c];
			dist2 += m * m;
		end
		rsum = 6 * (ra + rb);
		if (!(dist2 < rsum * rsum))
			return h;
		h.hit = 1'b1;
		if (dist2 == 0) begin
			h.n[1] = 16384;
		end else begin
			f = int_sqrt(dist2 << 16);
			for (int c = 0; c < 3; c++) begin
				m = d[c] < 0 ? -d[c] : d[c];
				q = longint'(((m << 22) + f / 2) / f);
				h.n[c] = d[c] < 0 ? -q : q;
			end
		end
		for (int c = 0; c < 3; c++) begin
			x = b[c] * 16384 + h.n[c] * 6 * rb;
			v = div_floor(x + 49152, 98304);
			if (v > 1048575)
				v = 1048575;
			if (v < -1048576)
				v = -1048576;
			h.p[c] = v;
		end
		return h;
	endfunction

	// Expected contact of one shape pair.
	function automatic contact_t predict_contact(logic [1:0] k1, logic [PACK_W-1:0] b1,
			logic [PACK_W-1:0] t1, logic [RAD_W-1:0] r1, logic [1:0] k2,
			logic [PACK_W-1:0] b2, logic [PACK_W-1:0] t2, logic [RAD_W-1:0] r2);
		contact_t res;
		sample_hit_t h;
		longint pa[3], pb[3];
		logic [PACK_W-1:0] cb, ct, xb;
		logic [RAD_W-1:0] cr, xr;
		h.hit = 1'b0;
		if (k1 == KIND_CAPSULE && k2 == KIND_CAPSULE) begin
			for (int i = 0; i < 3 && !h.hit; i++) begin
				sample_point(b1, t1, 3 * i, pa);
				for (int j = 0; j < 3 && !h.hit; j++) begin
					sample_point(b2, t2, 3 * j, pb);
					h = sphere_overlap(pa, r1, pb, r2);
				end
			end
		end else if ((k1 == KIND_CAPSULE && k2 == KIND_BOX)
				|| (k1 == KIND_BOX && k2 == KIND_CAPSULE)) begin
			// The capsule always plays the first shape.
			cb = k1 == KIND_CAPSULE ? b1 : b2;
			ct = k1 == KIND_CAPSULE ? t1 : t2;
			cr = k1 == KIND_CAPSULE ? r1 : r2;
			xb = k1 == KIND_CAPSULE ? b2 : b1;
			xr = k1 == KIND_CAPSULE ? r2 : r1;
			sample_point(xb, xb, 0, pb);
			for (int i = 0; i < 4 && !h.hit; i++) begin
				sample_point(cb, ct, 2 * i, pa);
				h = sphere_overlap(pa, cr, pb, xr);
			end
		end else begin
			sample_point(b1, b1, 0, pa);
			sample_point(b2, b2, 0, pb);
			h = sphere_overlap(pa, r1, pb, r2);
		end
		res.overlap = h.hit;
		res.normal = '0;
		res.point = '0;
		if (h.hit) begin
			for (int c = 0; c < 3; c++) begin
				res.normal[NRM_W*c +: NRM_W] = h.n[c][NRM_W-1:0];
				res.point[COORD_W*c +: COORD_W] = h.p[c][COORD_W-1:0];
			end
		end
		return res;
	endfunction

	// Sender: offers one pair word, with random gaps while idle_on is set, until it is taken.
	task automatic send_pair(logic [1:0] k1, logic [PACK_W-1:0] b1, logic [PACK_W-1:0] t1,
			logic [RAD_W-1:0] r1, logic [1:0] k2, logic [PACK_W-1:0] b2,
			logic [PACK_W-1:0] t2, logic [RAD_W-1:0] r2);
		while (idle_on && $urandom_range(99) < 38) begin
			pair.valid <= 1'b0;
			@(posedge clk);
		end
		pair.valid         <= 1'b1;
		pair.first_kind    <= k1;
		pair.first_base    <= b1;
		pair.first_tip     <= t1;
		pair.first_radius  <= r1;
		pair.second_kind   <= k2;
		pair.second_base   <= b2;
		pair.second_tip    <= t2;
		pair.second_radius <= r2;
		expected_contacts.push_back(predict_contact(k1, b1, t1, r1, k2, b2, t2, r2));
		@(posedge clk);
		while (!pair.ready)
			@(posedge clk);
	endtask

	function automatic logic [PACK_W-1:0] pack_point(longint x, longint y, longint z);
		logic [PACK_W-1:0] v;
		v = {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
		return v;
	endfunction

	// Random point near a centre, so that shapes often overlap.
	function automatic logic [PACK_W-1:0] near_point(logic [PACK_W-1:0] centre, int spread);
		return pack_point(coord_of(centre, 0) + $signed($urandom_range(2 * spread)) - spread,
			coord_of(centre, 1) + $signed($urandom_range(2 * spread)) - spread,
			coord_of(centre, 2) + $signed($urandom_range(2 * spread)) - spread);
	endfunction

	function automatic logic [PACK_W-1:0] any_point();
		return PACK_W'({$urandom(), $urandom()});
	endfunction

	task automatic test_directed();
		logic [PACK_W-1:0] o;
		o = '0;
		// Coincident centres give the up normal.
		send_pair(KIND_SPHERE, o, o, 16'd512, KIND_SPHERE, o, o, 16'd512);
		send_pair(KIND_BOX, o, o, 16'd1, KIND_SPHERE, o, o, 16'd0);
		// Zero radii never overlap, even when coincident.
		send_pair(KIND_SPHERE, o, o, 16'd0, KIND_BOX, o, o, 16'd0);
		send_pair(KIND_SPHERE, pack_point(512, 0, 0), o, 16'd400, KIND_SPHERE, o, o, 16'd200);
		send_pair(KIND_SPHERE, pack_point(0, -300, 0), o, 16'd400, KIND_BOX, o, o, 16'd200);
		send_pair(KIND_BOX, pack_point(5000, 0, 0), o, 16'd10, KIND_BOX, o, o, 16'd10);
		// Extremes of coordinates and radii, with saturated contact points.
		send_pair(KIND_SPHERE, pack_point(1048575, 1048575, 1048575), o, 16'hFFFF,
			KIND_SPHERE, pack_point(1048575, 1048575, 1048500), o, 16'hFFFF);
		send_pair(KIND_SPHERE, pack_point(-1048576, -1048576, -1048576), o, 16'hFFFF,
			KIND_SPHERE, pack_point(-1048500, -1048576, -1048576), o, 16'hFFFF);
		send_pair(KIND_SPHERE, pack_point(1048575, 1048575, 1048575), o, 16'hFFFF,
			KIND_SPHERE, pack_point(-1048576, -1048576, -1048576), o, 16'hFFFF);
		send_pair(KIND_SPHERE, {PACK_W{1'b1}}, {PACK_W{1'b1}}, 16'hFFFF,
			KIND_SPHERE, {PACK_W{1'b1}}, {PACK_W{1'b1}}, 16'hFFFF);
		// Capsule pairs: a miss at the tip end, a hit at the middle only and a clear miss.
		send_pair(KIND_CAPSULE, o, pack_point(4096, 0, 0), 16'd100,
			KIND_CAPSULE, pack_point(4096, 600, 0), pack_point(4096, 4000, 0), 16'd100);
		send_pair(KIND_CAPSULE, pack_point(-2048, 0, 0), pack_point(2048, 0, 0), 16'd50,
			KIND_CAPSULE, pack_point(0, -2048, 60), pack_point(0, 2048, 60), 16'd50);
		send_pair(KIND_CAPSULE, o, pack_point(0, 0, 2048), 16'd20,
			KIND_CAPSULE, pack_point(9000, 0, 0), pack_point(9000, 0, 2048), 16'd20);
		// Capsule against box at the thirds, both orders.
		send_pair(KIND_CAPSULE, o, pack_point(3072, 0, 0), 16'd30,
			KIND_BOX, pack_point(1024, 40, 0), o, 16'd30);
		send_pair(KIND_BOX, pack_point(2048, 0, 40), o, 16'd30,
			KIND_CAPSULE, o, pack_point(3072, 0, 0), 16'd30);
		send_pair(KIND_BOX, pack_point(9000, 0, 0), o, 16'd30,
			KIND_CAPSULE, o, pack_point(3072, 0, 0), 16'd30);
		// Capsule with sphere uses the bases only.
		send_pair(KIND_CAPSULE, o, pack_point(3072, 0, 0), 16'd30,
			KIND_SPHERE, pack_point(3072, 0, 0), o, 16'd30);
		send_pair(KIND_SPHERE, o, o, 16'd30, KIND_CAPSULE, pack_point(0, 10, 0),
			pack_point(5000, 0, 0), 16'd30);
		// Kind three acts as a sphere.
		send_pair(KIND_ODD, pack_point(20, 0, 0), pack_point(3000, 0, 0), 16'd30,
			KIND_CAPSULE, o, pack_point(0, 3000, 0), 16'd30);
		send_pair(KIND_CAPSULE, o, o, 16'd30, KIND_ODD, pack_point(0, 0, -50), o, 16'd30);
	endtask

	task automatic test_random(int count);
		logic [1:0] k1, k2;
		logic [PACK_W-1:0] b1, t1, b2, t2;
		logic [RAD_W-1:0] r1, r2;
		for (int n = 0; n < count; n++) begin
			k1 = KIND_W'($urandom_range(3));
			k2 = KIND_W'($urandom_range(3));
			if ($urandom_range(99) < 15) begin
				// Fully random words: every bit, mostly no overlap.
				b1 = any_point();
				t1 = any_point();
				b2 = any_point();
				t2 = any_point();
				r1 = RAD_W'($urandom());
				r2 = RAD_W'($urandom());
			end else begin
				b1 = any_point();
				t1 = near_point(b1, 1 << $urandom_range(14));
				b2 = near_point(b1, 1 << $urandom_range(14));
				t2 = near_point(b2, 1 << $urandom_range(14));
				r1 = RAD_W'($urandom_range(1 << $urandom_range(14)));
				r2 = RAD_W'($urandom_range(1 << $urandom_range(14)));
			end
			send_pair(k1, b1, t1, r1, k2, b2, t2, r2);
		end
	endtask

	// Long stall on the result side, so that the queue fills.
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (300)
					@(posedge clk);
				hold_off = 1'b0;
			end
			test_random(80);
		join
	endtask

	// Receiver: stalls at random while idle_on is set and throughout hold_off, and checks each result word.
	always @(posedge clk) begin
		contact_t e;
		if (result.valid && result.ready) begin
			if (expected_contacts.size() == 0) begin
				$error("result word with no expected contact");
				failed = 1'b1;
			end else begin
				e = expected_contacts.pop_front();
				if (result.overlap !== e.overlap) begin
					$error("overlap: expected %0h, actual %0h", e.overlap, result.overlap);
					failed = 1'b1;
				end
				if (result.contact_normal !== e.normal) begin
					$error("contact_normal: expected %0h, actual %0h", e.normal,
						result.contact_normal);
					failed = 1'b1;
				end
				if (result.contact_point !== e.point) begin
					$error("contact_point: expected %0h, actual %0h", e.point,
						result.contact_point);
					failed = 1'b1;
				end
			end
		end
		result.ready <= !hold_off && !(idle_on && $urandom_range(99) < 38);
	end

	// Stimulus sequence.
	initial begin
		int waited;
		failed = 1'b0;
		idle_on = 1'b0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		result.ready = 1'b0;
		pair.valid = 1'b0;
		pair.first_kind = '0;
		pair.first_base = '0;
		pair.first_tip = '0;
		pair.first_radius = '0;
		pair.second_kind = '0;
		pair.second_base = '0;
		pair.second_tip = '0;
		pair.second_radius = '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		idle_on = 1'b1;
		test_random(700);
		test_backpressure();
		test_random(300);
		pair.valid <= 1'b0;
		waited = 0;
		while (expected_contacts.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100)
			@(posedge clk);
		if (!failed && expected_contacts.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
